// ----- src/gaussian_blur_3x3_unit_assert.svh -----
// Assertion macros shared by the blur unit's RTL files.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef GAUSSIAN_BLUR_3X3_UNIT_ASSERT_SVH
`define GAUSSIAN_BLUR_3X3_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset
`define GB3_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define GB3_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GB3_CHECK(lbl, cond, msg)
`define GB3_CHECK_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- src/gb3_pkg.sv -----
// Shared constants and types for the 3x3 Gaussian blur unit.
// No dependencies; imported by every module of the block.
package gb3_pkg;

  // Default sizes handed to the top-level parameters
  localparam int DEF_MAX_WIDTH    = 2048;
  localparam int DEF_CHANNEL_BITS = 8;

  // Configuration register port
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_REG_BITS = 12;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_REG_BITS-1:0] RST_WIDTH  = 12'd640;
  localparam logic [CFG_REG_BITS-1:0] RST_HEIGHT = 12'd480;

  // Result queue depth in entries (each entry holds up to two results)
  localparam int OUTQ_DEPTH = 4;

  // Per-item control travelling from the counter stage to the window stage
  typedef struct packed {
    logic last_col;   // item sits in the last column of its row
    logic first_col;  // item sits in column zero
    logic emit;       // row is past the first, results are due
    logic row_zero;   // first row: line store reads count as zero
    logic fend;       // flush row: trailing result closes the frame
  } ctl_t;

endpackage

// ----- src/gb3_linemem.sv -----
// Line store for the two previous rows, one entry per column.
// Synchronous memory with a registered read and a bypass for a same-cycle write.
module gb3_linemem
  import gb3_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int DW    = 48
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] q_r;
  logic          byp_r;
  logic [DW-1:0] byp_data_r;

  // Read old contents, write new; remember a write that hits the read address
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r        <= mem_r[rd_addr];
      byp_r      <= wr_en && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  // Forward the colliding write over the stale read
  assign rd_data = byp_r ? byp_data_r : q_r;

endmodule

// ----- src/gb3_window.sv -----
// Window stage: merges line store reads with the new pixel, updates the
// 3x3 window and computes up to two blurred results. Uses gb3_pkg.
`include "gaussian_blur_3x3_unit_assert.svh"
module gb3_window
  import gb3_pkg::*;
#(
  parameter int CB = DEF_CHANNEL_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid,
  input  ctl_t              ctl,
  input  logic [3*CB-1:0]   pix,
  input  logic [6*CB-1:0]   line_q,
  output logic [6*CB-1:0]   line_d,
  output logic              push,
  output logic              two,
  output logic [3*CB+1:0]   res0,
  output logic [3*CB+1:0]   res1
);

  localparam int PW = 3 * CB;
  localparam int WW = 3 * PW;
  localparam int SW = CB + 4;

  logic [WW-1:0] wl_r, wl_nxt;
  logic [WW-1:0] wc_r;
  logic [WW-1:0] cur;
  logic [PW-1:0] up_px, mid_px;
  logic          emit_a, emit_b;
  logic [PW+1:0] res_a, res_b;

  // Kernel [1 2 1; 2 4 2; 1 2 1] over three columns of three rows, then >> 4
  function automatic logic [PW-1:0] blur(input logic [WW-1:0] lc, input logic [WW-1:0] cc,
                                         input logic [WW-1:0] rc);
    logic [SW-1:0] s;
    logic [PW-1:0] o;
    o = '0;
    for (int ch = 0; ch < 3; ch++) begin
      s = SW'(lc[ch*CB +: CB]) + (SW'(cc[ch*CB +: CB]) << 1) + SW'(rc[ch*CB +: CB])
        + (SW'(lc[PW+ch*CB +: CB]) << 1) + (SW'(cc[PW+ch*CB +: CB]) << 2)
        + (SW'(rc[PW+ch*CB +: CB]) << 1)
        + SW'(lc[2*PW+ch*CB +: CB]) + (SW'(cc[2*PW+ch*CB +: CB]) << 1)
        + SW'(rc[2*PW+ch*CB +: CB]);
      o[ch*CB +: CB] = s[SW-1:4];
    end
    return o;
  endfunction

  // Current column: upper and middle rows from the line store, bottom is the pixel
  assign up_px  = ctl.row_zero ? '0 : line_q[2*PW-1:PW];
  assign mid_px = ctl.row_zero ? '0 : line_q[PW-1:0];
  assign cur    = {pix, mid_px, up_px};
  assign line_d = {mid_px, pix};

  // Shift the window; column zero has no left neighbour
  assign wl_nxt = ctl.first_col ? '0 : wc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= '0;
      wc_r <= '0;
    end else if (valid) begin
      wl_r <= wl_nxt;
      wc_r <= cur;
    end
  end

  // Result for the previous column, then the right-edge result at row end
  assign emit_a = ctl.emit && !ctl.first_col;
  assign emit_b = ctl.emit && ctl.last_col;
  assign res_a  = {1'b0, !ctl.last_col, blur(wl_r, wc_r, cur)};
  assign res_b  = {ctl.fend, 1'b1, blur(wl_nxt, cur, '0)};

  assign push = valid && (emit_a || emit_b);
  assign two  = emit_a && emit_b;
  assign res0 = emit_a ? res_a : res_b;
  assign res1 = res_b;

  `GB3_CHECK_NEXT(a_col0_left_clear, valid && ctl.first_col, wl_r == '0,
                  "left window column not cleared after column zero")

endmodule

// ----- src/gb3_outq.sv -----
// Result queue: each entry holds one or two results of one item and is
// drained one result per handshake. Uses gb3_pkg.
`include "gaussian_blur_3x3_unit_assert.svh"
module gb3_outq
  import gb3_pkg::*;
#(
  parameter int RW    = 3 * DEF_CHANNEL_BITS + 2,
  parameter int DEPTH = OUTQ_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic                       two,
  input  logic [RW-1:0]              res0,
  input  logic [RW-1:0]              res1,
  output logic [$clog2(DEPTH+1)-1:0] level,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [RW-1:0]              out_data
);

  localparam int PTRW = $clog2(DEPTH);
  localparam int LVW  = $clog2(DEPTH + 1);
  localparam int EW   = 2 * RW + 1;

  logic [EW-1:0]   mem_r [DEPTH];
  logic [PTRW-1:0] wr_ptr_r, rd_ptr_r;
  logic [LVW-1:0]  level_r;
  logic            half_r;
  logic [EW-1:0]   head;
  logic            head_two;
  logic            pop_res, pop_entry;

  assign head      = mem_r[rd_ptr_r];
  assign head_two  = head[EW-1];
  assign out_valid = (level_r != '0);
  assign out_data  = half_r ? head[2*RW-1:RW] : head[RW-1:0];
  assign pop_res   = out_valid && out_ready;
  assign pop_entry = pop_res && (half_r || !head_two);
  assign level     = level_r;

  // Store the results of one item
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= {two, res1, res0};
    end
  end

  // Advance pointers, level and the half-entry marker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
      half_r   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_entry) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      level_r <= level_r + LVW'(push) - LVW'(pop_entry);
      if (pop_res) begin
        half_r <= !pop_entry;
      end
    end
  end

  `GB3_CHECK(a_no_overflow, !push || (level_r != LVW'(DEPTH)),
             "result pushed into a full queue")
  `GB3_CHECK(a_half_has_entry, !half_r || ((level_r != '0) && head_two),
             "second-result marker set without a paired entry")

endmodule

// ----- src/gaussian_blur_3x3_unit.sv -----
// 3x3 Gaussian blur unit, kernel [1 2 1; 2 4 2; 1 2 1] / 16, RGB raster stream.
// Throughput: one item per cycle while in_tready is high; the row-end item gives two
// results, which a 4-entry result queue absorbs.
// An item passes the stage-one register and then the result queue before its result can be taken.
// Reset (rst_n low at a clock edge): counters, window and queue clear, width
// 640, height 480; the line store is not cleared and holds whatever it held.
`include "gaussian_blur_3x3_unit_assert.svh"
module gaussian_blur_3x3_unit
  import gb3_pkg::*;
#(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input items
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0] in_tdata,  // red_in, green_in, blue_in
  input  logic                    in_tuser,                   // action
  // Result items
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [((3*CHANNEL_BITS+7)/8)*8-1:0] out_tdata, // red_out, green_out, blue_out
  output logic                    out_tlast,                  // run_last
  output logic                    out_tuser,                  // frame_end
  // Configuration writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_REG_BITS-1:0] cfg_data
);

  localparam int CB  = CHANNEL_BITS;
  localparam int PW  = 3 * CB;
  localparam int DW  = ((PW + 7) / 8) * 8;
  localparam int RW  = PW + 2;
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WB  = $clog2(MAX_WIDTH + 1);
  localparam int CW  = (WB > CFG_REG_BITS) ? WB : CFG_REG_BITS;
  localparam int LVW = $clog2(OUTQ_DEPTH + 1);

  logic [CFG_REG_BITS-1:0] width_r, height_r;
  logic [AW-1:0]           col_r, col_nxt;
  logic [CFG_REG_BITS-1:0] row_r, row_nxt;
  logic [CW-1:0]           w_ext, w_eff, col_ext, c_ext;
  logic [CFG_REG_BITS-1:0] h_eff;
  logic [AW-1:0]           col_c;
  logic                    last_col, row_ge_h, pad, accept;
  ctl_t                    ctl_in;

  logic                    s1_valid_r;
  ctl_t                    s1_ctl_r;
  logic [PW-1:0]           s1_pix_r;
  logic [AW-1:0]           s1_addr_r;

  logic [2*PW-1:0]         line_q, line_d;
  logic                    q_push, q_two;
  logic [RW-1:0]           q_res0, q_res1, q_out;
  logic [LVW-1:0]          q_level;

  // Configuration registers, written at any time the port is valid
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  width_r  <= cfg_data;
        CFG_IDX_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp width and height, locate the item in the frame
  assign w_ext    = CW'(width_r);
  assign w_eff    = (w_ext == '0) ? CW'(1)
                  : ((w_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_ext);
  assign h_eff    = (height_r == '0) ? CFG_REG_BITS'(1) : height_r;
  assign col_ext  = CW'(col_r);
  assign c_ext    = (col_ext < w_eff) ? col_ext : (w_eff - CW'(1));
  assign col_c    = c_ext[AW-1:0];
  assign last_col = (c_ext == (w_eff - CW'(1)));
  assign row_ge_h = (row_r >= h_eff);
  assign pad      = in_tuser || row_ge_h;

  assign ctl_in.last_col  = last_col;
  assign ctl_in.first_col = (col_c == '0);
  assign ctl_in.emit      = (row_r != '0);
  assign ctl_in.row_zero  = (row_r == '0);
  assign ctl_in.fend      = row_ge_h;

  // Accept while the queue has room for this item and the one in flight
  assign in_tready = ({1'b0, q_level} + (LVW+1)'(s1_valid_r)) <= (LVW+1)'(OUTQ_DEPTH - 1);
  assign accept    = in_tvalid && in_tready;

  assign col_nxt = last_col ? '0 : (col_c + 1'b1);
  assign row_nxt = last_col ? (row_ge_h ? '0 : (row_r + 1'b1)) : row_r;

  // Advance the frame position on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      s1_valid_r <= accept;
    end
  end

  // Hold the item for the window stage while the line store is read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r  <= ctl_in;
      s1_pix_r  <= pad ? '0 : in_tdata[PW-1:0];
      s1_addr_r <= col_c;
    end
  end

  gb3_linemem #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * PW)
  ) u_linemem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_c),
    .rd_data (line_q),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_addr_r),
    .wr_data (line_d)
  );

  gb3_window #(
    .CB (CB)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid  (s1_valid_r),
    .ctl    (s1_ctl_r),
    .pix    (s1_pix_r),
    .line_q (line_q),
    .line_d (line_d),
    .push   (q_push),
    .two    (q_two),
    .res0   (q_res0),
    .res1   (q_res1)
  );

  gb3_outq #(
    .RW    (RW),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .two       (q_two),
    .res0      (q_res0),
    .res1      (q_res1),
    .level     (q_level),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_out)
  );

  assign out_tdata = DW'(q_out[PW-1:0]);
  assign out_tlast = q_out[PW];
  assign out_tuser = q_out[PW+1];

  `GB3_CHECK_NEXT(a_row_end_wraps_col, accept && last_col, col_r == '0,
                  "column count not back at zero after the last column")

endmodule
